[design/rfg_pkg.sv]
// Package for the rectangle fill grid: default sizes, register indexes,
// command and status codes, and the controller/datapath interface structs.
// No dependencies.
`default_nettype none

package rfg_pkg;

  localparam int MAX_ROWS_DEF   = 64;
  localparam int MAX_COLS_DEF   = 64;
  localparam int VALUE_BITS_DEF = 32;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int CMD_W      = 2;
  localparam int STATUS_W   = 2;
  localparam int BOUND_W    = 7;
  localparam int POS_W      = 6;
  localparam int OUT_VAL_W  = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_IN_USE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FILL_INIT   = 2'd2;

  localparam logic [BOUND_W-1:0]    ROWS_RESET = 7'd64;
  localparam logic [BOUND_W-1:0]    COLS_RESET = 7'd64;
  localparam logic [CFG_DATA_W-1:0] INIT_RESET = 32'd0;

  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPLY = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_REJECT = 2'd2;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_FILL  = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef struct packed {
    logic accept;
    logic rd_in;
    logic fill_rd;
    logic clr_wr;
    logic clr_zero;
    logic capture;
    logic out_load;
  } ctl_cmd_t;

  typedef struct packed {
    op_t  op;
    logic sweep_last;
    logic fill_last;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

[design/rfg_ram.sv]
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
`default_nettype none

module rfg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[design/rfg_ctl.sv]
// Controller state machine for the rectangle fill grid: sequences the reset
// clearing pass, clear sweeps, row fills, reads and result hand-off.
// Depends on rfg_pkg.
`default_nettype none

module rfg_ctl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire rfg_pkg::dp_stat_t stat,
  output rfg_pkg::ctl_cmd_t      cmd
);

  typedef enum logic [5:0] {
    S_INIT      = 6'b000001,
    S_IDLE      = 6'b000010,
    S_CLEAR     = 6'b000100,
    S_FILL      = 6'b001000,
    S_READ_WAIT = 6'b010000,
    S_DONE      = 6'b100000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_stall  = 1'b1;
    case (state_r)
      S_INIT: begin
        cmd.clr_wr   = 1'b1;
        cmd.clr_zero = 1'b1;
        if (stat.sweep_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          case (stat.op)
            rfg_pkg::OP_CLEAR: state_nxt = S_CLEAR;
            rfg_pkg::OP_FILL:  state_nxt = S_FILL;
            rfg_pkg::OP_READ: begin
              cmd.rd_in = 1'b1;
              state_nxt = S_READ_WAIT;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.sweep_last) begin
          state_nxt = S_DONE;
        end
      end
      S_FILL: begin
        cmd.fill_rd = 1'b1;
        if (stat.fill_last) begin
          state_nxt = S_DONE;
        end
      end
      S_READ_WAIT: begin
        cmd.capture = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end

endmodule

`default_nettype wire

[design/rfg_dp.sv]
// Datapath for the rectangle fill grid: configuration registers, command
// decode, row counter, row-wide grid memory with read-merge-write, result regs.
// Depends on rfg_pkg and rfg_ram.
`default_nettype none

module rfg_dp #(
  parameter int MAX_ROWS   = rfg_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS   = rfg_pkg::MAX_COLS_DEF,
  parameter int VALUE_BITS = rfg_pkg::VALUE_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [rfg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [rfg_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic [rfg_pkg::CMD_W-1:0]          in_command,
  input  wire logic [rfg_pkg::BOUND_W-1:0]        in_row_top,
  input  wire logic [rfg_pkg::BOUND_W-1:0]        in_row_bottom,
  input  wire logic [rfg_pkg::BOUND_W-1:0]        in_col_left,
  input  wire logic [rfg_pkg::BOUND_W-1:0]        in_col_right,
  input  wire logic [rfg_pkg::CFG_DATA_W-1:0]     in_fill_value,
  input  wire logic [rfg_pkg::POS_W-1:0]          in_read_row,
  input  wire logic [rfg_pkg::POS_W-1:0]          in_read_col,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic      [rfg_pkg::OUT_VAL_W-1:0]      out_read_value,
  output logic      [rfg_pkg::STATUS_W-1:0]       out_status,
  input  wire rfg_pkg::ctl_cmd_t                  cmd,
  output rfg_pkg::dp_stat_t                       stat
);

  localparam int RA = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CA = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RW = ($clog2(MAX_ROWS + 1) > rfg_pkg::BOUND_W) ?
                      $clog2(MAX_ROWS + 1) : rfg_pkg::BOUND_W;
  localparam int CW = ($clog2(MAX_COLS + 1) > rfg_pkg::BOUND_W) ?
                      $clog2(MAX_COLS + 1) : rfg_pkg::BOUND_W;
  localparam int ROW_BITS = MAX_COLS * VALUE_BITS;

  logic [rfg_pkg::BOUND_W-1:0]    cfg_rows_r;
  logic [rfg_pkg::BOUND_W-1:0]    cfg_cols_r;
  logic [rfg_pkg::CFG_DATA_W-1:0] cfg_init_r;

  logic [RW-1:0]             cnt_r;
  logic [RW-1:0]             bot_r;
  logic [CW-1:0]             lft_r;
  logic [CW-1:0]             rgt_r;
  logic [VALUE_BITS-1:0]     val_r;
  logic [CA-1:0]             col_r;
  logic                      wb_valid_r;
  logic [RA-1:0]             wb_row_r;
  logic [rfg_pkg::OUT_VAL_W-1:0] res_value_r;
  logic [rfg_pkg::STATUS_W-1:0]  res_status_r;
  logic                          out_valid_r;
  logic [rfg_pkg::OUT_VAL_W-1:0] out_value_r;
  logic [rfg_pkg::STATUS_W-1:0]  out_status_r;

  logic [RW-1:0] rows_ext;
  logic [RW-1:0] rows_now;
  logic [CW-1:0] cols_ext;
  logic [CW-1:0] cols_now;
  logic [RW-1:0] top_ext;
  logic [RW-1:0] bot_ext;
  logic [CW-1:0] lft_ext;
  logic [CW-1:0] rgt_ext;
  logic [RW-1:0] rrow_ext;
  logic [CW-1:0] rcol_ext;
  logic          rect_bad;
  logic          rect_empty;
  logic          read_bad;
  rfg_pkg::op_t  op;
  logic [rfg_pkg::STATUS_W-1:0] st_code;

  logic                  ram_we;
  logic [RA-1:0]         ram_waddr;
  logic [ROW_BITS-1:0]   ram_wdata;
  logic                  ram_re;
  logic [RA-1:0]         ram_raddr;
  logic [ROW_BITS-1:0]   ram_rdata;
  logic [ROW_BITS-1:0]   merged;
  logic [VALUE_BITS-1:0] clr_cell;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_rows_r <= rfg_pkg::ROWS_RESET;
      cfg_cols_r <= rfg_pkg::COLS_RESET;
      cfg_init_r <= rfg_pkg::INIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        rfg_pkg::CFG_ROWS_IN_USE: cfg_rows_r <= cfg_data[rfg_pkg::BOUND_W-1:0];
        rfg_pkg::CFG_COLS_IN_USE: cfg_cols_r <= cfg_data[rfg_pkg::BOUND_W-1:0];
        rfg_pkg::CFG_FILL_INIT:   cfg_init_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    rows_ext = RW'(cfg_rows_r);
    cols_ext = CW'(cfg_cols_r);
    rows_now = (rows_ext > RW'(MAX_ROWS)) ? RW'(MAX_ROWS) : rows_ext;
    cols_now = (cols_ext > CW'(MAX_COLS)) ? CW'(MAX_COLS) : cols_ext;
    top_ext  = RW'(in_row_top);
    bot_ext  = RW'(in_row_bottom);
    lft_ext  = CW'(in_col_left);
    rgt_ext  = CW'(in_col_right);
    rrow_ext = RW'(in_read_row);
    rcol_ext = CW'(in_read_col);
    rect_bad = (top_ext > bot_ext) || (bot_ext > rows_now) ||
               (lft_ext > rgt_ext) || (rgt_ext > cols_now);
    rect_empty = (top_ext == bot_ext) || (lft_ext == rgt_ext);
    read_bad   = (rrow_ext >= rows_now) || (rcol_ext >= cols_now);
    op      = rfg_pkg::OP_NONE;
    st_code = rfg_pkg::ST_REJECT;
    case (in_command)
      rfg_pkg::CMD_CLEAR: begin
        op      = rfg_pkg::OP_CLEAR;
        st_code = rfg_pkg::ST_DONE;
      end
      rfg_pkg::CMD_APPLY: begin
        if (rect_bad) begin
          st_code = rfg_pkg::ST_REJECT;
        end else if (rect_empty) begin
          st_code = rfg_pkg::ST_EMPTY;
        end else begin
          op      = rfg_pkg::OP_FILL;
          st_code = rfg_pkg::ST_DONE;
        end
      end
      rfg_pkg::CMD_READ: begin
        if (!read_bad) begin
          op      = rfg_pkg::OP_READ;
          st_code = rfg_pkg::ST_DONE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      wb_valid_r <= 1'b0;
    end else begin
      wb_valid_r <= cmd.fill_rd;
      if (cmd.accept) begin
        cnt_r <= (op == rfg_pkg::OP_FILL) ? top_ext : '0;
      end else if (cmd.clr_wr || cmd.fill_rd) begin
        cnt_r <= cnt_r + RW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    wb_row_r <= cnt_r[RA-1:0];
    if (cmd.accept) begin
      bot_r        <= bot_ext;
      lft_r        <= lft_ext;
      rgt_r        <= rgt_ext;
      val_r        <= VALUE_BITS'(in_fill_value);
      col_r        <= rcol_ext[CA-1:0];
      res_status_r <= st_code;
      res_value_r  <= '0;
    end else if (cmd.capture) begin
      res_value_r <= rfg_pkg::OUT_VAL_W'(ram_rdata[col_r * VALUE_BITS +: VALUE_BITS]);
    end
  end

  always_comb begin
    for (int c = 0; c < MAX_COLS; c++) begin
      if ((CW'(c) >= lft_r) && (CW'(c) < rgt_r)) begin
        merged[c * VALUE_BITS +: VALUE_BITS] = val_r;
      end else begin
        merged[c * VALUE_BITS +: VALUE_BITS] = ram_rdata[c * VALUE_BITS +: VALUE_BITS];
      end
    end
  end

  assign clr_cell  = cmd.clr_zero ? '0 : VALUE_BITS'(cfg_init_r);
  assign ram_we    = wb_valid_r || cmd.clr_wr;
  assign ram_waddr = wb_valid_r ? wb_row_r : cnt_r[RA-1:0];
  assign ram_wdata = wb_valid_r ? merged : {MAX_COLS{clr_cell}};
  assign ram_re    = cmd.rd_in || cmd.fill_rd;
  assign ram_raddr = cmd.rd_in ? rrow_ext[RA-1:0] : cnt_r[RA-1:0];

  rfg_ram #(
    .WIDTH (ROW_BITS),
    .DEPTH (MAX_ROWS)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_value_r  <= res_value_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_value_r;
  assign out_status     = out_status_r;

  assign stat.op         = op;
  assign stat.sweep_last = (cnt_r == RW'(MAX_ROWS - 1));
  assign stat.fill_last  = ((cnt_r + RW'(1)) == bot_r);
  assign stat.out_free   = !out_valid_r || !out_stall;

endmodule

`default_nettype wire

[design/rectangle_fill_grid_core.sv]
// Rectangle fill grid top level. A clear writes every row, a fill rewrites rows
// row_top to row_bottom - 1, a read fetches one row; other items go to the result.
// The next item is taken once the result is in the output register.
// The grid memory holds one row per word and is written one row per cycle.
// After reset a clearing pass zeroes the grid; items are stalled during it and
// configuration writes are taken.
`default_nettype none

module rectangle_fill_grid_core #(
  parameter int MAX_ROWS   = rfg_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS   = rfg_pkg::MAX_COLS_DEF,
  parameter int VALUE_BITS = rfg_pkg::VALUE_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [rfg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [rfg_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [rfg_pkg::CMD_W-1:0]      in_command,
  input  wire logic [rfg_pkg::BOUND_W-1:0]    in_row_top,
  input  wire logic [rfg_pkg::BOUND_W-1:0]    in_row_bottom,
  input  wire logic [rfg_pkg::BOUND_W-1:0]    in_col_left,
  input  wire logic [rfg_pkg::BOUND_W-1:0]    in_col_right,
  input  wire logic [rfg_pkg::CFG_DATA_W-1:0] in_fill_value,
  input  wire logic [rfg_pkg::POS_W-1:0]      in_read_row,
  input  wire logic [rfg_pkg::POS_W-1:0]      in_read_col,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic      [rfg_pkg::OUT_VAL_W-1:0]  out_read_value,
  output logic      [rfg_pkg::STATUS_W-1:0]   out_status
);

  rfg_pkg::ctl_cmd_t ctl_cmd;
  rfg_pkg::dp_stat_t dp_stat;

  rfg_ctl u_ctl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (dp_stat),
    .cmd      (ctl_cmd)
  );

  rfg_dp #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLS   (MAX_COLS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_command     (in_command),
    .in_row_top     (in_row_top),
    .in_row_bottom  (in_row_bottom),
    .in_col_left    (in_col_left),
    .in_col_right   (in_col_right),
    .in_fill_value  (in_fill_value),
    .in_read_row    (in_read_row),
    .in_read_col    (in_read_col),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_read_value (out_read_value),
    .out_status     (out_status),
    .cmd            (ctl_cmd),
    .stat           (dp_stat)
  );

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_cmd.out_load |-> !(out_valid && out_stall))
    else $error("result loaded while output register is held");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_cmd.out_load |=> out_valid)
    else $error("loaded result not presented");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> !(ctl_cmd.clr_wr || ctl_cmd.fill_rd || ctl_cmd.capture))
    else $error("item accepted while grid work is in progress");

endmodule

`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for rectangle_fill_grid_core: directed and random clear,
// rectangle fill and read items under random idling on both channels and several sizes.
// Depends on rfg_pkg and the rectangle_fill_grid_core RTL.
module tb_top;
  import rfg_pkg::*;

  localparam int GRID_ROWS = MAX_ROWS_DEF;
  localparam int GRID_COLS = MAX_COLS_DEF;
  localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;
  localparam int CYCLE_LIMIT = 800000;
  localparam int SETTLE_CYCLES = MAX_ROWS_DEF + 8;
  localparam int MAX_WAIT = 18;

  typedef struct packed {
    logic [CMD_W-1:0]      command;
    logic [BOUND_W-1:0]    row_top;
    logic [BOUND_W-1:0]    row_bottom;
    logic [BOUND_W-1:0]    col_left;
    logic [BOUND_W-1:0]    col_right;
    logic [CFG_DATA_W-1:0] fill_value;
    logic [POS_W-1:0]      read_row;
    logic [POS_W-1:0]      read_col;
  } grid_cmd_t;

  typedef struct packed {
    logic [OUT_VAL_W-1:0] read_value;
    logic [STATUS_W-1:0]  status;
  } grid_reply_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [CMD_W-1:0]      in_command = '0;
  logic [BOUND_W-1:0]    in_row_top = '0;
  logic [BOUND_W-1:0]    in_row_bottom = '0;
  logic [BOUND_W-1:0]    in_col_left = '0;
  logic [BOUND_W-1:0]    in_col_right = '0;
  logic [CFG_DATA_W-1:0] in_fill_value = '0;
  logic [POS_W-1:0]      in_read_row = '0;
  logic [POS_W-1:0]      in_read_col = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [OUT_VAL_W-1:0]  out_read_value;
  logic [STATUS_W-1:0]   out_status;

  rectangle_fill_grid_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_row_top     (in_row_top),
    .in_row_bottom  (in_row_bottom),
    .in_col_left    (in_col_left),
    .in_col_right   (in_col_right),
    .in_fill_value  (in_fill_value),
    .in_read_row    (in_read_row),
    .in_read_col    (in_read_col),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_read_value (out_read_value),
    .out_status     (out_status)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  logic [OUT_VAL_W-1:0]  grid_model [GRID_ROWS][GRID_COLS];
  logic [BOUND_W-1:0]    rows_reg = ROWS_RESET;
  logic [BOUND_W-1:0]    cols_reg = COLS_RESET;
  logic [CFG_DATA_W-1:0] init_reg = INIT_RESET;

  grid_reply_t expected_replies[$];
  int error_count = 0;
  int cycle_count = 0;
  int stall_left = 0;
  bit no_idle = 1'b0;
  int n_clears = 0, n_fills = 0, n_reads = 0, n_unknown = 0;
  int n_rejected = 0, n_empty = 0, n_settings = 0;

  function automatic int rows_limit();
    return (int'(rows_reg) > GRID_ROWS) ? GRID_ROWS : int'(rows_reg);
  endfunction

  function automatic int cols_limit();
    return (int'(cols_reg) > GRID_COLS) ? GRID_COLS : int'(cols_reg);
  endfunction

  function automatic int draw_wait();
    if (no_idle) return 0;
    return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, MAX_WAIT);
  endfunction

  task automatic predict_grid_item(input grid_cmd_t c, output grid_reply_t r);
    int top, bot, lft, rgt, ri, ci;
    r = '0;
    top = int'(c.row_top);
    bot = int'(c.row_bottom);
    lft = int'(c.col_left);
    rgt = int'(c.col_right);
    r.status = ST_DONE;
    case (c.command)
      CMD_CLEAR: begin
        n_clears++;
        foreach (grid_model[i, j]) grid_model[i][j] = init_reg;
      end
      CMD_APPLY: begin
        n_fills++;
        if (top > bot || bot > rows_limit() || lft > rgt || rgt > cols_limit()) begin
          r.status = ST_REJECT;
        end else if (top == bot || lft == rgt) begin
          r.status = ST_EMPTY;
        end else begin
          for (ri = top; ri < bot; ri++)
            for (ci = lft; ci < rgt; ci++) grid_model[ri][ci] = c.fill_value;
        end
      end
      CMD_READ: begin
        n_reads++;
        if (int'(c.read_row) >= rows_limit() || int'(c.read_col) >= cols_limit()) begin
          r.status = ST_REJECT;
        end else begin
          r.read_value = grid_model[c.read_row][c.read_col];
        end
      end
      default: begin
        n_unknown++;
        r.status = ST_REJECT;
      end
    endcase
    if (r.status == ST_REJECT) n_rejected++;
    if (r.status == ST_EMPTY) n_empty++;
  endtask

  task automatic report_mismatch(input string what);
    $display("MISMATCH at cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  task automatic check_reply();
    grid_reply_t exp_r;
    if (expected_replies.size() == 0) begin
      report_mismatch($sformatf("result with no item pending (value %h status %0d)",
                                out_read_value, out_status));
    end else begin
      exp_r = expected_replies.pop_front();
      if (out_read_value !== exp_r.read_value)
        report_mismatch($sformatf("read_value %h, expected %h", out_read_value,
                                  exp_r.read_value));
      if (out_status !== exp_r.status)
        report_mismatch($sformatf("status %0d, expected %0d", out_status, exp_r.status));
    end
  endtask

  always @(posedge clk) begin : reply_monitor
    int hold;
    if (rst_n && out_valid && !out_stall) begin
      check_reply();
      hold = draw_wait();
      stall_left <= hold;
      out_stall <= (hold != 0);
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall <= (stall_left > 1);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results pending", cycle_count,
               expected_replies.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_item(input grid_cmd_t c);
    int gap;
    grid_reply_t r;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_command    <= c.command;
    in_row_top    <= c.row_top;
    in_row_bottom <= c.row_bottom;
    in_col_left   <= c.col_left;
    in_col_right  <= c.col_right;
    in_fill_value <= c.fill_value;
    in_read_row   <= c.read_row;
    in_read_col   <= c.read_col;
    do @(posedge clk); while (in_stall);
    predict_grid_item(c, r);
    expected_replies = {expected_replies, r};
  endtask

  task automatic wait_for_replies();
    in_valid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_config(input logic [BOUND_W-1:0] rows, input logic [BOUND_W-1:0] cols,
                            input logic [CFG_DATA_W-1:0] init);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ROWS_IN_USE;
    cfg_data  <= CFG_DATA_W'(rows);
    @(posedge clk);
    rows_reg = rows;
    cfg_index <= CFG_COLS_IN_USE;
    cfg_data  <= CFG_DATA_W'(cols);
    @(posedge clk);
    cols_reg = cols;
    cfg_index <= CFG_FILL_INIT;
    cfg_data  <= init;
    @(posedge clk);
    init_reg = init;
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  function automatic grid_cmd_t noise_item();
    grid_cmd_t c;
    c.command    = CMD_W'($urandom);
    c.row_top    = BOUND_W'($urandom);
    c.row_bottom = BOUND_W'($urandom);
    c.col_left   = BOUND_W'($urandom);
    c.col_right  = BOUND_W'($urandom);
    c.fill_value = $urandom;
    c.read_row   = POS_W'($urandom);
    c.read_col   = POS_W'($urandom);
    return c;
  endfunction

  function automatic grid_cmd_t fill_cmd(input int top, input int bot, input int lft,
                                         input int rgt, input logic [CFG_DATA_W-1:0] val);
    grid_cmd_t c;
    c = noise_item();
    c.command    = CMD_APPLY;
    c.row_top    = BOUND_W'(top);
    c.row_bottom = BOUND_W'(bot);
    c.col_left   = BOUND_W'(lft);
    c.col_right  = BOUND_W'(rgt);
    c.fill_value = val;
    return c;
  endfunction

  function automatic grid_cmd_t read_cmd(input int row, input int col);
    grid_cmd_t c;
    c = noise_item();
    c.command  = CMD_READ;
    c.read_row = POS_W'(row);
    c.read_col = POS_W'(col);
    return c;
  endfunction

  function automatic grid_cmd_t plain_cmd(input logic [CMD_W-1:0] cmd);
    grid_cmd_t c;
    c = noise_item();
    c.command = cmd;
    return c;
  endfunction

  function automatic grid_cmd_t rand_item();
    grid_cmd_t c;
    int kind, rl, cl, top, h;
    c = noise_item();
    rl = rows_limit();
    cl = cols_limit();
    kind = $urandom_range(0, 99);
    if (kind < 3) begin
      c.command = CMD_CLEAR;
    end else if (kind < 5) begin
      c.command = CMD_UNKNOWN;
    end else if (kind < 52) begin
      c.command = CMD_APPLY;
      if ($urandom_range(0, 9) != 0) begin
        top = $urandom_range(0, rl);
        h = ($urandom_range(0, 7) == 0) ? rl - top : $urandom_range(0, 4);
        if (h > rl - top) h = rl - top;
        c.row_top    = BOUND_W'(top);
        c.row_bottom = BOUND_W'(top + h);
        c.col_left   = BOUND_W'($urandom_range(0, cl));
        c.col_right  = BOUND_W'($urandom_range(int'(c.col_left), cl));
      end
      if ($urandom_range(0, 7) == 0) c.fill_value = ($urandom_range(0, 1) == 0) ? '0 : '1;
    end else begin
      c.command = CMD_READ;
      if (rl > 0 && cl > 0 && $urandom_range(0, 9) != 0) begin
        c.read_row = POS_W'($urandom_range(0, rl - 1));
        c.read_col = POS_W'($urandom_range(0, cl - 1));
      end
    end
    return c;
  endfunction

  task automatic send_random(input int count);
    repeat (count) send_item(rand_item());
  endtask

  task automatic test_after_reset();
    send_item(read_cmd(0, 0));
    send_item(read_cmd(GRID_ROWS - 1, GRID_COLS - 1));
    send_item(read_cmd(31, 7));
    send_item(plain_cmd(CMD_UNKNOWN));
  endtask

  task automatic test_rectangle_edges();
    send_item(fill_cmd(0, GRID_ROWS, 0, GRID_COLS, '1));
    send_item(read_cmd(0, 0));
    send_item(read_cmd(GRID_ROWS - 1, GRID_COLS - 1));
    send_item(fill_cmd(GRID_ROWS - 1, GRID_ROWS, GRID_COLS - 1, GRID_COLS, 32'hA5A5_5A5A));
    send_item(read_cmd(GRID_ROWS - 1, GRID_COLS - 1));
    send_item(read_cmd(GRID_ROWS - 2, GRID_COLS - 1));
    send_item(fill_cmd(10, 10, 0, GRID_COLS, 32'h1));
    send_item(fill_cmd(0, GRID_ROWS, 5, 5, 32'h2));
    send_item(fill_cmd(9, 8, 0, 4, 32'h3));
    send_item(fill_cmd(0, GRID_ROWS + 1, 0, 4, 32'h4));
    send_item(fill_cmd(0, 4, 0, 127, 32'h5));
    send_item(fill_cmd(0, 4, 6, 5, 32'h6));
    send_item(fill_cmd(127, 127, 0, 0, 32'h7));
    send_item(fill_cmd(GRID_ROWS, GRID_ROWS, GRID_COLS, GRID_COLS, 32'h8));
    send_item(read_cmd(10, 3));
    send_item(plain_cmd(CMD_CLEAR));
    send_item(read_cmd(GRID_ROWS - 1, 0));
  endtask

  task automatic test_size_registers();
    wait_for_replies();
    set_config(7'd0, 7'd64, 32'h1234_5678);
    send_random(16);
    wait_for_replies();
    set_config(7'd1, 7'd1, 32'hFFFF_FFFF);
    send_item(plain_cmd(CMD_CLEAR));
    send_random(15);
    wait_for_replies();
    set_config(7'd64, 7'd0, 32'h0000_0000);
    send_random(16);
    wait_for_replies();
    set_config(7'd127, 7'd127, $urandom);
    send_random(16);
    wait_for_replies();
    set_config(7'd33, 7'd17, $urandom);
    send_random(16);
    wait_for_replies();
    set_config(7'd64, 7'd64, 32'h0000_0000);
    send_random(16);
  endtask

  function automatic logic [BOUND_W-1:0] pick_size();
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return BOUND_W'($urandom_range(0, 127));
    if (k < 4) return BOUND_W'($urandom_range(1, 64));
    return 7'd64;
  endfunction

  task automatic test_random_traffic();
    for (int phase = 0; phase < 13; phase++) begin
      wait_for_replies();
      no_idle = (phase % 4 == 3);
      set_config(pick_size(), pick_size(), $urandom);
      if ($urandom_range(0, 1) == 0) send_item(plain_cmd(CMD_CLEAR));
      send_random(80);
    end
    no_idle = 1'b0;
  endtask

  initial begin
    foreach (grid_model[i, j]) grid_model[i][j] = INIT_RESET;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_after_reset();
    test_rectangle_edges();
    test_size_registers();
    test_random_traffic();
    wait_for_replies();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Ran %0d clears, %0d fills, %0d reads and %0d unknown commands over %0d sizes.",
             n_clears, n_fills, n_reads, n_unknown, n_settings);
    $display("%0d items were rejected and %0d rectangles were empty.", n_rejected, n_empty);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches", error_count);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[sim.f]
design/rfg_pkg.sv
design/rfg_ram.sv
design/rfg_ctl.sv
design/rfg_dp.sv
design/rectangle_fill_grid_core.sv
tb/tb_top.sv
